// ===== hw/rtl/bba_pkg.sv =====
package bba_pkg;

	// disk and bitmap geometry
	localparam int MaxBlocks       = 4096;
	localparam int BitsPerMapBlock = 32768;
	localparam int WordW           = 32;
	localparam int MapWords        = MaxBlocks / WordW;
	localparam int AddrW           = $clog2(MapWords);
	localparam int BitW            = $clog2(WordW);
	localparam int MapShift        = $clog2(BitsPerMapBlock);

	// field widths
	localparam int CmdW    = 2;
	localparam int BlkW    = 12;
	localparam int LimW    = 13;
	localparam int StatusW = 2;

	// first block that allocate may hand out, first bitmap block on disk
	localparam int FirstAlloc = 3;
	localparam int MapBase    = 2;

	// command codes
	localparam logic [CmdW-1:0] CmdQuery = 2'd0;
	localparam logic [CmdW-1:0] CmdFree  = 2'd1;
	localparam logic [CmdW-1:0] CmdAlloc = 2'd2;
	localparam logic [CmdW-1:0] CmdNone  = 2'd3;

	// status codes
	localparam logic [StatusW-1:0] StatDone    = 2'd0;
	localparam logic [StatusW-1:0] StatNoSpace = 2'd1;
	localparam logic [StatusW-1:0] StatNoRange = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHK,
		ST_SCAN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [StatusW-1:0] status;
		logic               is_free;
		logic [BlkW-1:0]    allocated_block;
		logic [BlkW-1:0]    wb_block;
	} result_t;

	typedef struct packed {
		logic            found;
		logic [BitW-1:0] bit_idx;
	} scan_res_t;

endpackage

// ===== hw/rtl/bba_ram.sv =====
module bba_ram #(
	parameter int Width = 32,
	parameter int Depth = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/bba_scan.sv =====
module bba_scan (
	input  logic [bba_pkg::WordW-1:0] word,
	input  logic                      is_first,
	input  logic                      is_last,
	input  logic [bba_pkg::BitW-1:0]  last_bit,
	output bba_pkg::scan_res_t        res
);

	logic [bba_pkg::WordW-1:0] masked;

	// keep only bits inside the allocatable window
	always_comb begin
		for (int j = 0; j < bba_pkg::WordW; j++) begin
			masked[j] = word[j]
				&& !(is_first && (j < bba_pkg::FirstAlloc))
				&& !(is_last && (bba_pkg::BitW'(j) > last_bit));
		end
	end

	// lowest set bit wins
	always_comb begin
		res = '0;
		for (int j = bba_pkg::WordW - 1; j >= 0; j--) begin
			if (masked[j]) begin
				res.found   = 1'b1;
				res.bit_idx = bba_pkg::BitW'(j);
			end
		end
	end

endmodule

// ===== hw/rtl/block_bitmap_allocator_unit.sv =====
// first-fit free-block bitmap allocator, 128 x 32-bit map in one ram
// query and free: read the map word, then check it or write it back
// query, free or allocate rejected by the limit: no map access
// allocate: one map word per cycle through the find-first unit
// one command at a time; input ready only while idle, result held in an output register
// reset: async active low, map reads all zero through per-word valid flags, limit zero
module block_bitmap_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: total_blocks
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [11:0] block_number, rest zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] command
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [0] is_free, [12:1] allocated_block, [24:13] wb_block
	output logic [1:0]  m_axis_tuser   // [1:0] status
);

	localparam int AddrW = bba_pkg::AddrW;
	localparam int BitW  = bba_pkg::BitW;
	localparam int BlkW  = bba_pkg::BlkW;
	localparam int LimW  = bba_pkg::LimW;
	localparam int WordW = bba_pkg::WordW;

	bba_pkg::state_t  state_q, state_d;
	bba_pkg::result_t res_q, res_d, out_q;

	logic [LimW-1:0]           total_q;
	logic [bba_pkg::CmdW-1:0]  cmd_q, cmd_d;
	logic [BlkW-1:0]           blk_q, blk_d;
	logic [AddrW:0]            scan_q, scan_d;
	logic                      chk_vld_q, chk_vld_d;
	logic [AddrW-1:0]          chk_addr_q, chk_addr_d;
	logic [AddrW-1:0]          last_q, last_d;
	logic [BitW-1:0]           lastbit_q, lastbit_d;
	logic                      out_vld_q;
	logic                      out_load;

	logic                      valid_q [bba_pkg::MapWords];
	logic                      rd_valid_q;

	logic                      ram_we, ram_re;
	logic [AddrW-1:0]          ram_waddr, ram_raddr;
	logic [WordW-1:0]          ram_wdata, ram_rdata, word_rd;

	logic [LimW-1:0]           lim, lim_m1;
	logic                      in_xfer, in_range;
	logic [bba_pkg::CmdW-1:0]  s_cmd;
	logic [BlkW-1:0]           s_blk, found_blk;
	bba_pkg::scan_res_t        scan_res;

	assign s_cmd   = s_axis_tuser;
	assign s_blk   = s_axis_tdata[BlkW-1:0];
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = (state_q == bba_pkg::ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {7'd0, out_q.wb_block, out_q.allocated_block, out_q.is_free};

	// usable limit, saturated at the map size
	assign lim      = (total_q > LimW'(bba_pkg::MaxBlocks)) ? LimW'(bba_pkg::MaxBlocks) : total_q;
	assign lim_m1   = lim - LimW'(1);
	assign in_range = {1'b0, s_blk} < lim;

	// words never written read as zero
	assign word_rd = rd_valid_q ? ram_rdata : '0;

	assign found_blk = BlkW'({chk_addr_q, scan_res.bit_idx});

	bba_ram #(
		.Width(WordW),
		.Depth(bba_pkg::MapWords)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bba_scan u_scan (
		.word    (word_rd),
		.is_first(chk_addr_q == '0),
		.is_last (chk_addr_q == last_q),
		.last_bit(lastbit_q),
		.res     (scan_res)
	);

	// sequencer: next state, ram control and result
	always_comb begin
		state_d    = state_q;
		res_d      = res_q;
		cmd_d      = cmd_q;
		blk_d      = blk_q;
		scan_d     = scan_q;
		chk_vld_d  = 1'b0;
		chk_addr_d = chk_addr_q;
		last_d     = last_q;
		lastbit_d  = lastbit_q;
		ram_re     = 1'b0;
		ram_raddr  = s_blk[BitW +: AddrW];
		ram_we     = 1'b0;
		ram_waddr  = chk_addr_q;
		ram_wdata  = word_rd;
		out_load   = 1'b0;
		unique case (state_q)
			bba_pkg::ST_IDLE: begin
				if (in_xfer) begin
					cmd_d = s_cmd;
					blk_d = s_blk;
					res_d = '0;
					unique case (s_cmd)
						bba_pkg::CmdQuery: begin
							if (in_range) begin
								ram_re  = 1'b1;
								state_d = bba_pkg::ST_CHK;
							end else begin
								state_d = bba_pkg::ST_RESP;
							end
						end
						bba_pkg::CmdFree: begin
							if (in_range && (s_blk != '0)) begin
								ram_re  = 1'b1;
								state_d = bba_pkg::ST_CHK;
							end else begin
								res_d.status = bba_pkg::StatNoRange;
								state_d      = bba_pkg::ST_RESP;
							end
						end
						bba_pkg::CmdAlloc: begin
							if (lim > LimW'(bba_pkg::FirstAlloc)) begin
								scan_d    = '0;
								last_d    = lim_m1[BitW +: AddrW];
								lastbit_d = lim_m1[BitW-1:0];
								state_d   = bba_pkg::ST_SCAN;
							end else begin
								res_d.status = bba_pkg::StatNoSpace;
								state_d      = bba_pkg::ST_RESP;
							end
						end
						default: begin
							state_d = bba_pkg::ST_RESP;
						end
					endcase
				end
			end
			bba_pkg::ST_CHK: begin
				if (cmd_q == bba_pkg::CmdQuery) begin
					res_d.is_free = word_rd[blk_q[BitW-1:0]];
				end else begin
					ram_we    = 1'b1;
					ram_waddr = blk_q[BitW +: AddrW];
					ram_wdata = word_rd | (WordW'(1) << blk_q[BitW-1:0]);
				end
				state_d = bba_pkg::ST_RESP;
			end
			bba_pkg::ST_SCAN: begin
				// issue the next word read while the previous word is checked
				if (scan_q <= {1'b0, last_q}) begin
					ram_re     = 1'b1;
					ram_raddr  = scan_q[AddrW-1:0];
					scan_d     = scan_q + (AddrW+1)'(1);
					chk_vld_d  = 1'b1;
					chk_addr_d = scan_q[AddrW-1:0];
				end
				if (chk_vld_q) begin
					if (scan_res.found) begin
						ram_we                = 1'b1;
						ram_wdata             = word_rd & ~(WordW'(1) << scan_res.bit_idx);
						res_d.allocated_block = found_blk;
						res_d.wb_block        = BlkW'((32'(found_blk) >> bba_pkg::MapShift)
							+ 32'(bba_pkg::MapBase));
						chk_vld_d             = 1'b0;
						state_d               = bba_pkg::ST_RESP;
					end else if (chk_addr_q == last_q) begin
						res_d.status = bba_pkg::StatNoSpace;
						chk_vld_d    = 1'b0;
						state_d      = bba_pkg::ST_RESP;
					end
				end
			end
			bba_pkg::ST_RESP: begin
				if (!out_vld_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = bba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bba_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bba_pkg::ST_IDLE;
			total_q   <= '0;
			chk_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			chk_vld_q <= chk_vld_d;
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// per-word written flags, and the flag of the word being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bba_pkg::MapWords; i++) begin
				valid_q[i] <= 1'b0;
			end
			rd_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (ram_re) begin
				rd_valid_q <= valid_q[ram_raddr];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		res_q      <= res_d;
		cmd_q      <= cmd_d;
		blk_q      <= blk_d;
		scan_q     <= scan_d;
		chk_addr_q <= chk_addr_d;
		last_q     <= last_d;
		lastbit_q  <= lastbit_d;
		if (out_load) begin
			out_q <= res_q;
		end
	end

endmodule

// ===== tb/tb_block_bitmap_allocator_unit.sv =====
module tb_block_bitmap_allocator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles without any transfer before the run is declared hung
	localparam int HangLimit = 5000;
	// length of the long receiver hold-off
	localparam int HoldCycles = 400;
	// cycles to wait after the last result
	localparam int TailCycles = 150;

	// free-map predictor and result checker
	class alloc_scoreboard;
		logic [bba_pkg::MaxBlocks-1:0] free_bits;
		logic [bba_pkg::LimW-1:0]      total_blocks;
		bba_pkg::result_t              expected_results[$];
		int                            errors;

		function new();
			free_bits    = '0;
			total_blocks = '0;
			errors       = 0;
		endfunction

		function void set_total(logic [bba_pkg::LimW-1:0] value);
			total_blocks = value;
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction

		// apply one accepted command to the map and queue its result
		function void note_command(logic [bba_pkg::CmdW-1:0] cmd,
			logic [bba_pkg::BlkW-1:0] blk);
			int               lim;
			int               b;
			bit               found;
			bba_pkg::result_t r;
			lim   = (total_blocks > bba_pkg::MaxBlocks) ? bba_pkg::MaxBlocks
				: int'(total_blocks);
			r     = '0;
			found = 1'b0;
			case (cmd)
				bba_pkg::CmdQuery: begin
					r.is_free = (int'(blk) < lim) && free_bits[blk];
				end
				bba_pkg::CmdFree: begin
					if (blk == 0 || int'(blk) >= lim)
						r.status = bba_pkg::StatNoRange;
					else
						free_bits[blk] = 1'b1;
				end
				bba_pkg::CmdAlloc: begin
					r.status = bba_pkg::StatNoSpace;
					// first fit from the lowest allocatable block
					for (b = bba_pkg::FirstAlloc; b < lim; b++) begin
						if (!found && free_bits[b]) begin
							found              = 1'b1;
							free_bits[b]       = 1'b0;
							r.status           = bba_pkg::StatDone;
							r.allocated_block  = b[bba_pkg::BlkW-1:0];
							r.wb_block         = bba_pkg::BlkW'(b / bba_pkg::BitsPerMapBlock
								+ bba_pkg::MapBase);
						end
					end
				end
				default: ;
			endcase
			expected_results.push_back(r);
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		// compare one result transfer with the oldest expectation
		task check_result(logic [bba_pkg::StatusW-1:0] status, logic [31:0] data);
			bba_pkg::result_t e;
			if (expected_results.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				e = expected_results.pop_front();
				if (status !== e.status)
					report_mismatch($sformatf("status %0d, expected %0d", status, e.status));
				if (data[0] !== e.is_free)
					report_mismatch($sformatf("is_free %0d, expected %0d", data[0], e.is_free));
				if (data[12:1] !== e.allocated_block)
					report_mismatch($sformatf("allocated_block %0d, expected %0d",
						data[12:1], e.allocated_block));
				if (data[24:13] !== e.wb_block)
					report_mismatch($sformatf("wb_block %0d, expected %0d",
						data[24:13], e.wb_block));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [12:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	alloc_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cur_limit = 0;
	int hang_count = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	block_bitmap_allocator_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	initial sb = new();

	// result side ready, with random stalls and one long hold-off
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			m_axis_tready <= 1'b0;
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// check every result transfer
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata);
	end

	// count cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			hang_count <= 0;
		else
			hang_count <= hang_count + 1;
	end

	initial begin
		while (hang_count < HangLimit)
			@(posedge clk);
		$display("FAIL block_bitmap_allocator_unit");
		$finish;
	end

	// write total_blocks while the block is idle
	task automatic write_total_blocks(input logic [12:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_total(value);
		cur_limit = (value > bba_pkg::MaxBlocks) ? bba_pkg::MaxBlocks : int'(value);
	endtask

	// offer one command and wait for its transfer
	task automatic send_command(input logic [1:0] cmd, input logic [11:0] blk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0000, blk};
		s_axis_tuser  <= cmd;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_command(cmd, blk);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// random mix weighted toward frees and allocates, blocks mostly up to just past the limit
	task automatic run_random_commands(input int n);
		int         i;
		int         pick;
		int         span;
		logic [1:0] cmd;
		logic [11:0] blk;
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 40)
				cmd = bba_pkg::CmdFree;
			else if (pick < 70)
				cmd = bba_pkg::CmdAlloc;
			else if (pick < 95)
				cmd = bba_pkg::CmdQuery;
			else
				cmd = bba_pkg::CmdNone;
			span = (cur_limit + 8 > 4095) ? 4095 : cur_limit + 8;
			if ($urandom_range(9) == 0)
				blk = 12'($urandom);
			else
				blk = 12'($urandom_range(span));
			send_command(cmd, blk);
		end
	endtask

	initial begin
		logic [12:0] limits[9];
		int          p;
		limits[0] = 13'd40;
		limits[1] = 13'd8191;
		limits[2] = 13'd3;
		limits[3] = 13'd1;
		limits[4] = 13'd100;
		limits[5] = 13'($urandom_range(8191));
		limits[6] = 13'd4095;
		limits[7] = 13'd2048;
		limits[8] = 13'd64;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_idle_pct = 24;
		recv_idle_pct = 72;

		// no superblock: everything out of range
		write_total_blocks(13'd0);
		send_command(bba_pkg::CmdQuery, 12'd0);
		send_command(bba_pkg::CmdQuery, 12'hfff);
		send_command(bba_pkg::CmdFree, 12'd5);
		send_command(bba_pkg::CmdFree, 12'd0);
		send_command(bba_pkg::CmdAlloc, 12'd0);
		send_command(bba_pkg::CmdNone, 12'hfff);
		drain_results();

		// full size disk: edges, low blocks skipped by allocate, map full
		write_total_blocks(13'd4096);
		send_command(bba_pkg::CmdFree, 12'd0);
		send_command(bba_pkg::CmdFree, 12'hfff);
		send_command(bba_pkg::CmdQuery, 12'hfff);
		send_command(bba_pkg::CmdQuery, 12'hffe);
		send_command(bba_pkg::CmdFree, 12'd1);
		send_command(bba_pkg::CmdFree, 12'd2);
		send_command(bba_pkg::CmdAlloc, 12'h000);
		send_command(bba_pkg::CmdAlloc, 12'hfff);
		send_command(bba_pkg::CmdFree, 12'd3);
		send_command(bba_pkg::CmdQuery, 12'd3);
		send_command(bba_pkg::CmdAlloc, 12'd0);
		send_command(bba_pkg::CmdNone, 12'd1);
		send_command(bba_pkg::CmdFree, 12'haaa);
		send_command(bba_pkg::CmdFree, 12'h555);
		send_command(bba_pkg::CmdAlloc, 12'd0);
		send_command(bba_pkg::CmdQuery, 12'haaa);
		drain_results();

		// random phases over several limits and idle profiles
		for (p = 0; p < 9; p++) begin
			if (p < 3) begin
				send_idle_pct = 24;
				recv_idle_pct = 72;
			end else if (p < 6) begin
				send_idle_pct = 72;
				recv_idle_pct = 24;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_total_blocks(limits[p]);
			if (p == 6)
				hold_req = 1'b1;
			run_random_commands(80);
			drain_results();
		end

		repeat (TailCycles) @(posedge clk);
		if (sb.outstanding() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.outstanding()));
		if (sb.errors == 0)
			$display("PASS block_bitmap_allocator_unit");
		else
			$display("FAIL block_bitmap_allocator_unit");
		$finish;
	end

endmodule

// ===== block_bitmap_allocator_unit.f =====
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_scan.sv
hw/rtl/block_bitmap_allocator_unit.sv
tb/tb_block_bitmap_allocator_unit.sv
